@@ hw/rtl/hmd5_pkg.sv @@
// ----------------------------------------------------------------------------
// hmd5_pkg
// Shared types, constants and round functions of the HMAC-MD5 engine.
// ----------------------------------------------------------------------------
package hmd5_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [31:0] IPAD_WORD = 32'h36363636;
   localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
   localparam logic [7:0] PAD_MARK = 8'h80;
   // Bit length of the outer message: one pad block plus the inner digest.
   localparam logic [31:0] OUTER_BITS = 32'd640;
   localparam logic [63:0] PAD_BLOCK_BITS = 64'd512;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

   localparam logic CSR_KEY_LOW = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   typedef enum logic [1:0] {
      BLK_BUF,
      BLK_IPAD,
      BLK_OPAD,
      BLK_OFIN
   } blk_mode_type;

   typedef enum logic [1:0] {
      BYTE_MSG,
      BYTE_MARK,
      BYTE_ZERO,
      BYTE_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         load_item;
      logic         clr_msg;
      logic         wr_byte;
      byte_sel_type byte_sel;
      logic [2:0]   byte_idx;
      logic         iv_load;
      logic         blk_start;
      blk_mode_type blk_mode;
      logic         outer;
      logic         round;
      logic [5:0]   rnd;
      logic         fold;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic [5:0] pos;
      logic [3:0] count;
      logic       last;
      logic       rsp_busy;
   } status_type;

   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5_s(input logic [5:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Message word index; only the low four bits of the round matter mod 16.
   function automatic logic [3:0] md5_g(input logic [5:0] i);
      logic [3:0] g;
      case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
         2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
         2'd3: g = 4'(i[3:0] * 4'd7);
         default: g = 4'd0;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] md5_f(input logic [1:0] q, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (q)
         2'd0: f = (b & c) | (~b & d);
         2'd1: f = (b & d) | (c & ~d);
         2'd2: f = b ^ c ^ d;
         2'd3: f = c ^ (b | ~d);
         default: f = 32'h0;
      endcase
      return f;
   endfunction

endpackage

@@ hw/rtl/hmd5_datapath.sv @@
// ----------------------------------------------------------------------------
// hmd5_datapath
// Block buffer, chaining values, MD5 round unit and result register.
// ----------------------------------------------------------------------------
module hmd5_datapath #(
   parameter int BYTES_PER_ITEM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hmd5_pkg::cmd_type    cmd,
   output hmd5_pkg::status_type status,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic [63:0]          req_data_word,
   input  logic [3:0]           req_valid_bytes,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_digest_low,
   output logic [63:0]          rsp_digest_high
);

   localparam logic [3:0] MaxBytes = 4'(BYTES_PER_ITEM);

   logic [63:0] key_low_ff, key_high_ff;
   logic [63:0] data_ff;
   logic [3:0]  count_ff;
   logic        last_ff;
   logic [31:0] wbuf_ff [16];
   logic [5:0]  pos_ff;
   logic [63:0] bits_ff;
   logic [31:0] hi_ff [4];
   logic [31:0] ho_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   hmd5_pkg::blk_mode_type mode_ff;
   logic        outer_ff;
   logic        rsp_valid_ff;
   logic [127:0] digest_ff;

   logic [63:0] len_in;
   logic [7:0]  byte_in;
   logic [3:0]  g;
   logic [31:0] m, t, rot;
   logic [63:0] rot_wide;
   logic [31:0] pad_word;
   logic [31:0] key_word;

   always_comb begin
      len_in = (bits_ff + hmd5_pkg::PAD_BLOCK_BITS) >> {pos_ff[2:0], 3'b000};
      case (cmd.byte_sel)
         hmd5_pkg::BYTE_MSG:  byte_in = data_ff[{cmd.byte_idx, 3'b000} +: 8];
         hmd5_pkg::BYTE_MARK: byte_in = hmd5_pkg::PAD_MARK;
         hmd5_pkg::BYTE_ZERO: byte_in = 8'h00;
         hmd5_pkg::BYTE_LEN:  byte_in = len_in[7:0];
         default:             byte_in = 8'h00;
      endcase
   end

   always_comb begin
      g = hmd5_pkg::md5_g(cmd.rnd);
      case (g[1:0])
         2'd0: key_word = key_low_ff[31:0];
         2'd1: key_word = key_low_ff[63:32];
         2'd2: key_word = key_high_ff[31:0];
         2'd3: key_word = key_high_ff[63:32];
         default: key_word = 32'h0;
      endcase
      pad_word = (g < 4'd4) ? key_word : 32'h0;
      case (mode_ff)
         hmd5_pkg::BLK_BUF:  m = wbuf_ff[g];
         hmd5_pkg::BLK_IPAD: m = pad_word ^ hmd5_pkg::IPAD_WORD;
         hmd5_pkg::BLK_OPAD: m = pad_word ^ hmd5_pkg::OPAD_WORD;
         hmd5_pkg::BLK_OFIN: begin
            if (g < 4'd4) m = hi_ff[g[1:0]];
            else if (g == 4'd4) m = {24'h0, hmd5_pkg::PAD_MARK};
            else if (g == 4'd14) m = hmd5_pkg::OUTER_BITS;
            else m = 32'h0;
         end
         default: m = 32'h0;
      endcase
      t = a_ff + hmd5_pkg::md5_f(cmd.rnd[5:4], b_ff, c_ff, d_ff)
          + hmd5_pkg::md5_k(cmd.rnd) + m;
      rot_wide = {t, t} << hmd5_pkg::md5_s(cmd.rnd);
      rot = rot_wide[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff   <= 64'h0;
         key_high_ff  <= 64'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == hmd5_pkg::CSR_KEY_HIGH) key_high_ff <= csr_wdata;
            else key_low_ff <= csr_wdata;
         end
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         data_ff  <= req_data_word;
         count_ff <= (req_valid_bytes > MaxBytes) ? MaxBytes : req_valid_bytes;
         last_ff  <= req_last;
      end
      if (cmd.clr_msg) begin
         pos_ff  <= 6'd0;
         bits_ff <= 64'd0;
      end else if (cmd.wr_byte) begin
         wbuf_ff[pos_ff[5:2]][{pos_ff[1:0], 3'b000} +: 8] <= byte_in;
         pos_ff <= pos_ff + 6'd1;
         if (cmd.byte_sel == hmd5_pkg::BYTE_MSG) bits_ff <= bits_ff + 64'd8;
      end
      if (cmd.iv_load) begin
         if (cmd.outer) begin
            ho_ff[0] <= hmd5_pkg::IV_A; ho_ff[1] <= hmd5_pkg::IV_B;
            ho_ff[2] <= hmd5_pkg::IV_C; ho_ff[3] <= hmd5_pkg::IV_D;
         end else begin
            hi_ff[0] <= hmd5_pkg::IV_A; hi_ff[1] <= hmd5_pkg::IV_B;
            hi_ff[2] <= hmd5_pkg::IV_C; hi_ff[3] <= hmd5_pkg::IV_D;
         end
      end
      if (cmd.blk_start) begin
         mode_ff  <= cmd.blk_mode;
         outer_ff <= cmd.outer;
         if (cmd.outer) begin
            a_ff <= ho_ff[0]; b_ff <= ho_ff[1]; c_ff <= ho_ff[2]; d_ff <= ho_ff[3];
         end else begin
            a_ff <= hi_ff[0]; b_ff <= hi_ff[1]; c_ff <= hi_ff[2]; d_ff <= hi_ff[3];
         end
      end else if (cmd.round) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + rot;
      end
      if (cmd.fold) begin
         if (outer_ff) begin
            ho_ff[0] <= ho_ff[0] + a_ff; ho_ff[1] <= ho_ff[1] + b_ff;
            ho_ff[2] <= ho_ff[2] + c_ff; ho_ff[3] <= ho_ff[3] + d_ff;
         end else begin
            hi_ff[0] <= hi_ff[0] + a_ff; hi_ff[1] <= hi_ff[1] + b_ff;
            hi_ff[2] <= hi_ff[2] + c_ff; hi_ff[3] <= hi_ff[3] + d_ff;
         end
      end
      if (cmd.out_load) digest_ff <= {ho_ff[3], ho_ff[2], ho_ff[1], ho_ff[0]};
   end

   assign status.pos      = pos_ff;
   assign status.count    = count_ff;
   assign status.last     = last_ff;
   assign status.rsp_busy = rsp_valid_ff & rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_low  = digest_ff[63:0];
   assign rsp_digest_high = digest_ff[127:64];

endmodule

@@ hw/rtl/hmd5_ctrl.sv @@
// ----------------------------------------------------------------------------
// hmd5_ctrl
// Sequencer: byte loading, padding, block rounds and the outer hash.
// ----------------------------------------------------------------------------
module hmd5_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output hmd5_pkg::cmd_type    cmd,
   input  hmd5_pkg::status_type status
);

   typedef enum logic [3:0] {
      S_IDLE, S_IPAD, S_BYTES, S_PAD80, S_PADZ, S_PLEN,
      S_OIV, S_OPAD, S_OFIN, S_RUN, S_FOLD, S_DONE
   } state_type;

   state_type  state_ff, state_in, ret_ff, ret_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [3:0] idx_ff, idx_in;
   logic       started_ff, started_in;

   always_comb begin
      cmd        = '0;
      cmd.rnd    = rnd_ff;
      cmd.byte_idx = idx_ff[2:0];
      state_in   = state_ff;
      ret_in     = ret_ff;
      rnd_in     = rnd_ff;
      idx_in     = idx_ff;
      started_in = started_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               idx_in = 4'd0;
               if (!started_ff) begin
                  cmd.iv_load = 1'b1;
                  cmd.clr_msg = 1'b1;
                  started_in = 1'b1;
                  state_in = S_IPAD;
               end else begin
                  state_in = S_BYTES;
               end
            end
         end
         S_IPAD: begin
            cmd.blk_start = 1'b1;
            cmd.blk_mode = hmd5_pkg::BLK_IPAD;
            ret_in = S_BYTES;
            rnd_in = 6'd0;
            state_in = S_RUN;
         end
         S_BYTES: begin
            if (idx_ff < status.count) begin
               cmd.wr_byte = 1'b1;
               cmd.byte_sel = hmd5_pkg::BYTE_MSG;
               idx_in = idx_ff + 4'd1;
               if (status.pos == hmd5_pkg::LAST_POS) begin
                  cmd.blk_start = 1'b1;
                  cmd.blk_mode = hmd5_pkg::BLK_BUF;
                  ret_in = S_BYTES;
                  rnd_in = 6'd0;
                  state_in = S_RUN;
               end
            end else if (status.last) begin
               state_in = S_PAD80;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD80: begin
            cmd.wr_byte = 1'b1;
            cmd.byte_sel = hmd5_pkg::BYTE_MARK;
            state_in = S_PADZ;
            if (status.pos == hmd5_pkg::LAST_POS) begin
               cmd.blk_start = 1'b1;
               cmd.blk_mode = hmd5_pkg::BLK_BUF;
               ret_in = S_PADZ;
               rnd_in = 6'd0;
               state_in = S_RUN;
            end
         end
         S_PADZ: begin
            if (status.pos == hmd5_pkg::LEN_POS) begin
               state_in = S_PLEN;
            end else begin
               cmd.wr_byte = 1'b1;
               cmd.byte_sel = hmd5_pkg::BYTE_ZERO;
               if (status.pos == hmd5_pkg::LAST_POS) begin
                  cmd.blk_start = 1'b1;
                  cmd.blk_mode = hmd5_pkg::BLK_BUF;
                  ret_in = S_PADZ;
                  rnd_in = 6'd0;
                  state_in = S_RUN;
               end
            end
         end
         S_PLEN: begin
            cmd.wr_byte = 1'b1;
            cmd.byte_sel = hmd5_pkg::BYTE_LEN;
            if (status.pos == hmd5_pkg::LAST_POS) begin
               cmd.blk_start = 1'b1;
               cmd.blk_mode = hmd5_pkg::BLK_BUF;
               ret_in = S_OIV;
               rnd_in = 6'd0;
               state_in = S_RUN;
            end
         end
         S_OIV: begin
            cmd.iv_load = 1'b1;
            cmd.outer = 1'b1;
            state_in = S_OPAD;
         end
         S_OPAD: begin
            cmd.blk_start = 1'b1;
            cmd.blk_mode = hmd5_pkg::BLK_OPAD;
            cmd.outer = 1'b1;
            ret_in = S_OFIN;
            rnd_in = 6'd0;
            state_in = S_RUN;
         end
         S_OFIN: begin
            cmd.blk_start = 1'b1;
            cmd.blk_mode = hmd5_pkg::BLK_OFIN;
            cmd.outer = 1'b1;
            ret_in = S_DONE;
            rnd_in = 6'd0;
            state_in = S_RUN;
         end
         S_RUN: begin
            cmd.round = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == hmd5_pkg::LAST_POS) state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         S_DONE: begin
            // The previous digest must have left the output register first.
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               started_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ret_ff     <= S_IDLE;
         rnd_ff     <= 6'd0;
         idx_ff     <= 4'd0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         rnd_ff     <= rnd_in;
         idx_ff     <= idx_in;
         started_ff <= started_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_byte, cmd.round, cmd.fold, cmd.iv_load}))
      else $error("more than one datapath action in a cycle");
   a_round_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && rnd_ff == hmd5_pkg::LAST_POS) |=> state_ff == S_FOLD)
      else $error("round counter did not end in fold");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !status.rsp_busy)
      else $error("digest overwrote a stalled result");

endmodule

@@ hw/rtl/hmac_md5_engine_core.sv @@
// ----------------------------------------------------------------------------
// hmac_md5_engine_core
// HMAC-MD5 over a streamed message with a 16-byte key in two registers.
// ----------------------------------------------------------------------------
// Usage: write the key through csr_we/csr_index/csr_wdata while idle. Send
// the message as beats on req_* (up to eight bytes per beat, count in
// req_valid_bytes, req_last on the final beat; an empty message is a single
// beat with count zero and last set). Only a last beat produces a beat on
// rsp_*, carrying the 128-bit digest.
// The first beat of a message also runs the inner key block. A beat is
// accepted, its bytes are loaded one per cycle, and it is closed; each
// filled 64-byte block pauses the loading for 64 rounds of the single
// round unit plus a fold. No new beat is taken until the sequencer is idle.
// A last beat adds padding, one or two inner blocks and two outer blocks
// before the digest appears.
// Reset clears the sequencer, the key and the output valid; the next beat
// starts a new message. A stalled digest stays in the output register and
// the block keeps accepting beats; it holds only when a new digest is ready
// before the old one was taken.
// ----------------------------------------------------------------------------
module hmac_md5_engine_core #(
   parameter int BYTES_PER_ITEM = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_low,
   output logic [63:0] rsp_digest_high
);

   hmd5_pkg::cmd_type    cmd;
   hmd5_pkg::status_type status;

   hmd5_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   hmd5_datapath #(
      .BYTES_PER_ITEM (BYTES_PER_ITEM)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_low  (rsp_digest_low),
      .rsp_digest_high (rsp_digest_high)
   );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// HMAC-MD5 engine testbench
// Streams keyed messages through the engine with random sender gaps and
// receiver stalls, and compares every digest beat against a local HMAC-MD5
// predictor.
// ----------------------------------------------------------------------------
module testbench;

   localparam bit KEY_LOW_IDX = hmd5_pkg::CSR_KEY_LOW;
   localparam bit KEY_HIGH_IDX = hmd5_pkg::CSR_KEY_HIGH;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE_CYCLES = 600;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
   } digest_type;

   class hmac_scoreboard;
      bit [31:0] sine_k[64];
      bit [4:0] shift_amt[16];
      bit [63:0] key_lo, key_hi;
      bit [127:0] inner_chain;
      bit [511:0] blk_bytes;
      bit [63:0] bit_count;
      bit in_message;
      digest_type digests[$];
      int errors;

      function new();
         real r;
         int unsigned sh[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
         for (int i = 0; i < 64; i++) begin
            r = $sin(i + 1);
            if (r < 0.0) r = -r;
            sine_k[i] = 32'(longint'($floor(r * 4294967296.0)));
         end
         for (int i = 0; i < 16; i++) shift_amt[i] = sh[i];
         key_lo = 0;
         key_hi = 0;
         bit_count = 0;
         in_message = 0;
         errors = 0;
      endfunction

      function bit [127:0] compress(bit [127:0] h, bit [511:0] blk);
         bit [31:0] a, b, c, d, f, t;
         int g;
         bit [4:0] s;
         a = h[31:0]; b = h[63:32]; c = h[95:64]; d = h[127:96];
         for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
               f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
               f = (b & d) | (c & ~d); g = (5 * i + 1) % 16;
            end else if (i < 48) begin
               f = b ^ c ^ d; g = (3 * i + 5) % 16;
            end else begin
               f = c ^ (b | ~d); g = (7 * i) % 16;
            end
            s = shift_amt[(i / 16) * 4 + (i % 4)];
            t = a + f + sine_k[i] + blk[32 * g +: 32];
            a = d; d = c; c = b;
            b = b + ((t << s) | (t >> (32 - s)));
         end
         return {h[127:96] + d, h[95:64] + c, h[63:32] + b, h[31:0] + a};
      endfunction

      // MD5 tail: pad mark, zeros and the little-endian bit length.
      function bit [127:0] finish(bit [127:0] h, bit [511:0] blk, int fill, bit [63:0] bits);
         blk[8 * fill +: 8] = 8'h80;
         for (int i = fill + 1; i < 64; i++) blk[8 * i +: 8] = 8'h00;
         if (fill >= 56) begin
            h = compress(h, blk);
            blk = '0;
         end
         blk[511:448] = bits;
         return compress(h, blk);
      endfunction

      function bit [511:0] key_block(bit [7:0] pad);
         return {{48{pad}}, {key_hi, key_lo} ^ {16{pad}}};
      endfunction

      function bit [127:0] md5_iv();
         return {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
      endfunction

      function void set_key(bit [63:0] lo, bit [63:0] hi);
         key_lo = lo;
         key_hi = hi;
      endfunction

      function void note(bit [63:0] data, bit [3:0] nbytes, bit last);
         int n, pos;
         bit [127:0] outer;
         bit [511:0] ob;
         n = (nbytes > 8) ? 8 : nbytes;
         if (!in_message) begin
            inner_chain = compress(md5_iv(), key_block(8'h36));
            bit_count = 0;
            in_message = 1;
         end
         for (int i = 0; i < n; i++) begin
            pos = bit_count[8:3];
            blk_bytes[8 * pos +: 8] = data[8 * i +: 8];
            bit_count += 8;
            if (pos == 63) inner_chain = compress(inner_chain, blk_bytes);
         end
         if (last) begin
            inner_chain = finish(inner_chain, blk_bytes, bit_count[8:3], bit_count + 64'd512);
            outer = compress(md5_iv(), key_block(8'h5c));
            ob = '0;
            ob[127:0] = inner_chain;
            outer = finish(outer, ob, 16, 64'd640);
            digests.push_back('{low: outer[63:0], high: outer[127:64]});
            in_message = 0;
            bit_count = 0;
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check(bit [63:0] low, bit [63:0] high);
         digest_type exp_d;
         if (digests.size() == 0) begin
            report($sformatf("unexpected digest %h_%h", high, low));
            return;
         end
         exp_d = digests.pop_front();
         if (low !== exp_d.low)
            report($sformatf("digest_low %h, expected %h", low, exp_d.low));
         if (high !== exp_d.high)
            report($sformatf("digest_high %h, expected %h", high, exp_d.high));
      endtask

      function int pending();
         return digests.size();
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic csr_index = KEY_LOW_IDX;
   logic [63:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [63:0] req_data_word = '0;
   logic [3:0] req_valid_bytes = '0;
   logic req_last = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [63:0] rsp_digest_low, rsp_digest_high;

   hmac_scoreboard sb = new();
   int cycles = 0;
   int items_sent = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   hmac_md5_engine_core dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_word(req_data_word), .req_valid_bytes(req_valid_bytes),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_digest_low(rsp_digest_low), .rsp_digest_high(rsp_digest_high)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // The receiver switches at random among free-running, random and heavy stall modes.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(50, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_digest_low, rsp_digest_high);
   end

   task automatic send_beat(input logic [63:0] data, input logic [3:0] nbytes,
                            input logic last);
      req_valid <= 1'b1;
      req_data_word <= data;
      req_valid_bytes <= nbytes;
      req_last <= last;
      do @(posedge clock); while (req_stall);
      sb.note(data, nbytes, last);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // Lets every digest drain and the engine finish any block still in flight.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(input logic [63:0] lo, input logic [63:0] hi);
      csr_we <= 1'b1;
      csr_index <= KEY_LOW_IDX;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= KEY_HIGH_IDX;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_key(lo, hi);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Beats of random bytes, mostly full; any beat may carry a random count from zero to fifteen.
   task automatic send_message(input int nbeats);
      logic [3:0] nb;
      for (int i = 0; i < nbeats; i++) begin
         nb = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
         send_beat(rand64(), nb, i == nbeats - 1);
      end
   endtask

   initial begin
      int msgs;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = $urandom_range(1, 24);

      // Empty message under the reset key, then a one-byte message.
      send_beat('0, 4'd0, 1'b1);
      drain();
      write_key('1, '1);
      send_beat('0, 4'd1, 1'b1);
      // 56 bytes forces a second padding block; 55 bytes just fits.
      for (int i = 0; i < 7; i++) send_beat('1, 4'd8, i == 6);
      for (int i = 0; i < 7; i++) send_beat('1, (i == 6) ? 4'd7 : 4'd8, i == 6);
      // A count above eight is taken as eight.
      send_beat(64'h0123456789abcdef, 4'd15, 1'b1);
      drain();
      // Key changed mid-message: the outer pad must use the new key.
      send_beat(rand64(), 4'd8, 1'b0);
      send_beat(rand64(), 4'd5, 1'b0);
      drain();
      write_key(64'h0, 64'h0);
      send_beat(rand64(), 4'd9, 1'b1);
      drain();

      msgs = 0;
      while (items_sent < 1200) begin
         if (msgs % 12 == 11) begin
            drain();
            case ($urandom_range(0, 3))
               0: write_key('0, '0);
               1: write_key('1, '1);
               default: write_key(rand64(), rand64());
            endcase
         end
         if ($urandom_range(0, 19) == 0) begin
            send_message(20);
         end else if ($urandom_range(0, 24) == 0) begin
            send_beat(rand64(), 4'd8, 1'b0);
            drain();
            write_key(rand64(), rand64());
            send_message($urandom_range(1, 4));
         end else begin
            send_message($urandom_range(1, 10));
         end
         msgs++;
      end

      drain();
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
